// ----- hdl/imucal_pkg.sv -----
// Shared types, constants and helpers for the IMU calibration block.
// No dependencies; imported by the lane, merge and top-level modules.

package imucal_pkg;

    localparam int GAIN_FRAC_BITS = 14;
    localparam int AXES           = 3;
    localparam int SAMPLE_W       = 16;
    localparam int TIME_W         = 32;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_ADDR_W     = 6;

    localparam logic signed [SAMPLE_W-1:0] GAIN_ONE  = SAMPLE_W'(1 << GAIN_FRAC_BITS);
    localparam logic [TIME_W-1:0]          TIMEOUT_RESET = 32'd60000;

    localparam logic signed [32:0] SAT_MAX = 33'sd32767;
    localparam logic signed [32:0] SAT_MIN = -33'sd32768;

    typedef enum logic [2:0] {
        REG_ACCEL_GAINS   = 3'd0,
        REG_ACCEL_OFFSETS = 3'd1,
        REG_GYRO_OFFSETS  = 3'd2,
        REG_GYRO_DEADBAND = 3'd3,
        REG_IDLE_TIMEOUT  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic load;
        logic cal;
    } lane_ctl_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel;
        logic signed [SAMPLE_W-1:0] gyro;
        logic                       moving;
    } lane_res_t;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [32:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = 16'sh7fff;
        end
        else if (v < SAT_MIN)
        begin
            r = -16'sh8000;
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/imucal_lane.sv -----
// One axis lane: accel gain multiply and offset, gyro offset and deadband, or raw bypass.
// Depends on imucal_pkg; the product is registered before shift and saturation.

module imucal_lane
    import imucal_pkg::*;
(
    input  logic                       clk,
    input  lane_ctl_t                  ctl,
    input  logic signed [SAMPLE_W-1:0] accel_raw,
    input  logic signed [SAMPLE_W-1:0] gyro_raw,
    input  logic signed [SAMPLE_W-1:0] gain,
    input  logic signed [SAMPLE_W-1:0] accel_offset,
    input  logic signed [SAMPLE_W-1:0] gyro_offset,
    input  logic [14:0]                deadband,
    output lane_res_t                  res
);

    logic signed [31:0]         prod_reg;
    logic signed [31:0]         prod_next;
    logic signed [SAMPLE_W:0]   gdiff_reg;
    logic signed [SAMPLE_W:0]   gdiff_next;
    logic signed [SAMPLE_W-1:0] araw_reg;
    logic signed [SAMPLE_W-1:0] graw_reg;

    logic signed [31:0]         shifted;
    logic signed [32:0]         accel_q;
    logic [SAMPLE_W:0]          gyro_mag;
    logic signed [SAMPLE_W-1:0] accel_cal;
    logic signed [SAMPLE_W-1:0] gyro_cal;

    assign prod_next  = accel_raw * gain;
    assign gdiff_next = {gyro_raw[SAMPLE_W-1], gyro_raw}
                      - {gyro_offset[SAMPLE_W-1], gyro_offset};

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            prod_reg  <= prod_next;
            gdiff_reg <= gdiff_next;
            araw_reg  <= accel_raw;
            graw_reg  <= gyro_raw;
        end
    end

    always_comb
    begin
        shifted   = prod_reg >>> GAIN_FRAC_BITS;
        accel_q   = {shifted[31], shifted} - {{17{accel_offset[SAMPLE_W-1]}}, accel_offset};
        accel_cal = sat16(accel_q);
        gyro_mag  = gdiff_reg[SAMPLE_W] ? 17'(-gdiff_reg) : 17'(gdiff_reg);
        if (gyro_mag < {2'b00, deadband})
        begin
            gyro_cal = '0;
        end
        else
        begin
            gyro_cal = sat16({{16{gdiff_reg[SAMPLE_W]}}, gdiff_reg});
        end
        res.accel  = ctl.cal ? accel_cal : araw_reg;
        res.gyro   = ctl.cal ? gyro_cal : graw_reg;
        res.moving = (res.gyro != '0);
    end

endmodule

// ----- hdl/imucal_merge.sv -----
// Merge stage: combines the lane results, tracks the last motion time and
// registers the output request. Depends on imucal_pkg.

module imucal_merge
    import imucal_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  lane_res_t [AXES-1:0]     lanes,
    input  logic [TIME_W-1:0]        now_ms,
    input  logic [TIME_W-1:0]        idle_timeout_ms,
    output logic [6*SAMPLE_W-1:0]    data,
    output logic                     sleep_request
);

    logic [TIME_W-1:0]     last_motion_reg;
    logic [TIME_W-1:0]     last_motion_next;
    logic [6*SAMPLE_W-1:0] data_reg;
    logic [6*SAMPLE_W-1:0] data_next;
    logic                  sleep_reg;
    logic                  sleep_next;
    logic                  motion;

    always_comb
    begin
        motion = 1'b0;
        for (int i = 0; i < AXES; i++)
        begin
            motion = motion | lanes[i].moving;
            data_next[SAMPLE_W*i +: SAMPLE_W]        = lanes[i].accel;
            data_next[SAMPLE_W*(i+AXES) +: SAMPLE_W] = lanes[i].gyro;
        end
        last_motion_next = (load && motion) ? now_ms : last_motion_reg;
        sleep_next       = (TIME_W'(now_ms - last_motion_next) > idle_timeout_ms);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_motion_reg <= '0;
        end
        else
        begin
            last_motion_reg <= last_motion_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg  <= data_next;
            sleep_reg <= sleep_next;
        end
    end

    assign data          = data_reg;
    assign sleep_request = sleep_reg;

endmodule

// ----- hdl/imu_calibrate_deadband_idle_core.sv -----
// Top level of the IMU calibration block: stream handshake, APB registers,
// three axis lanes and the merge stage. Depends on imucal_pkg, imucal_lane, imucal_merge.
//
// Takes one sample per cycle while the output is not stalled, in a multiply stage and
// an output stage: the first holds the 16x16 gain multiply of each axis lane, the
// second the shift, offset, saturation, deadband and idle comparison, which ends in the
// output register. A new request is taken while a finished one waits at the output,
// as long as the multiply stage is free. The idle decision of each sample uses the
// last motion time once that sample's own gyro results have updated it.

module imu_calibrate_deadband_idle_core
    import imucal_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [127:0]          s_tdata,   // accel_x_raw, accel_y_raw, accel_z_raw,
                                             // gyro_x_raw, gyro_y_raw, gyro_z_raw, now_ms
    input  logic                  s_tuser,   // apply_calibration
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [95:0]           m_tdata,   // accel_x_out, accel_y_out, accel_z_out,
                                             // gyro_x_out, gyro_y_out, gyro_z_out
    output logic                  m_tuser,   // sleep_request
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [47:0]       gains_reg;
    logic [47:0]       aoffs_reg;
    logic [47:0]       goffs_reg;
    logic [14:0]       deadband_reg;
    logic [TIME_W-1:0] timeout_reg;
    reg_idx_t          reg_idx;
    logic              cfg_write;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              cal_reg;
    logic [TIME_W-1:0] now_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              out_free;
    logic              out_load;
    logic              in_load;

    lane_ctl_t            lane_ctl;
    lane_res_t [AXES-1:0] lane_res;

    assign reg_idx   = reg_idx_t'(paddr[5:3]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg    <= {AXES{GAIN_ONE}};
            aoffs_reg    <= '0;
            goffs_reg    <= '0;
            deadband_reg <= '0;
            timeout_reg  <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_ACCEL_GAINS:   gains_reg    <= pwdata[47:0];
                REG_ACCEL_OFFSETS: aoffs_reg    <= pwdata[47:0];
                REG_GYRO_OFFSETS:  goffs_reg    <= pwdata[47:0];
                REG_GYRO_DEADBAND: deadband_reg <= pwdata[14:0];
                REG_IDLE_TIMEOUT:  timeout_reg  <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ACCEL_GAINS:   prdata = {16'd0, gains_reg};
            REG_ACCEL_OFFSETS: prdata = {16'd0, aoffs_reg};
            REG_GYRO_OFFSETS:  prdata = {16'd0, goffs_reg};
            REG_GYRO_DEADBAND: prdata = {49'd0, deadband_reg};
            REG_IDLE_TIMEOUT:  prdata = {32'd0, timeout_reg};
            default:           prdata = '0;
        endcase
    end

    assign out_free = !m_valid_reg || m_tready;
    assign out_load = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign in_load  = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = in_load || (s1_valid_reg && !out_free);
        m_valid_next  = out_load || (m_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            cal_reg <= s_tuser;
            now_reg <= s_tdata[127:96];
        end
    end

    assign lane_ctl.load = in_load;
    assign lane_ctl.cal  = cal_reg;

    for (genvar i = 0; i < AXES; i++)
    begin : g_lane
        imucal_lane u_lane (
            .clk          (clk),
            .ctl          (lane_ctl),
            .accel_raw    (s_tdata[SAMPLE_W*i +: SAMPLE_W]),
            .gyro_raw     (s_tdata[SAMPLE_W*(i+AXES) +: SAMPLE_W]),
            .gain         (gains_reg[SAMPLE_W*i +: SAMPLE_W]),
            .accel_offset (aoffs_reg[SAMPLE_W*i +: SAMPLE_W]),
            .gyro_offset  (goffs_reg[SAMPLE_W*i +: SAMPLE_W]),
            .deadband     (deadband_reg),
            .res          (lane_res[i])
        );
    end

    imucal_merge u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (out_load),
        .lanes           (lane_res),
        .now_ms          (now_reg),
        .idle_timeout_ms (timeout_reg),
        .data            (m_tdata),
        .sleep_request   (m_tuser)
    );

    assign m_tvalid = m_valid_reg;

    // hold a sampled request while the output stage is blocked
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg)
        else $error("multiply stage lost a request");

    // advance into the output register always leaves a valid result
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_valid_reg)
        else $error("output register not filled after advance");

    // an empty output register never holds back the input side
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with empty output");

    // no request reaches the output without passing the multiply stage
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg && !m_valid_reg |=> !m_valid_reg)
        else $error("result appeared without a request");

endmodule
